[rtl/bitwise_op_byte_trace_emitter_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the byte trace emitter
// Clocked property checks that drop out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef BITWISE_OP_BYTE_TRACE_EMITTER_MACROS_SVH
`define BITWISE_OP_BYTE_TRACE_EMITTER_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define BTO_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BTO_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define BTO_ASSERT(lbl, clk, rst_n, prop, msg)
`define BTO_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/bto_pkg.sv]
// ---------------------------------------------------------------------------
// Byte trace emitter package
// Shared constants, command codes and the queued word layout.
// ---------------------------------------------------------------------------
package bto_pkg;

  localparam int MAX_BYTES = 16;
  localparam int VAL_W     = 128;
  localparam int CNT_W     = 5;   // holds a byte count up to MAX_BYTES
  localparam int STAMP_W   = 32;

  // Operation codes
  localparam logic [1:0] CMD_AND = 2'd0;
  localparam logic [1:0] CMD_OR  = 2'd1;
  localparam logic [1:0] CMD_XOR = 2'd2;

  // Width tags
  localparam logic [2:0] TAG_1B  = 3'd1;
  localparam logic [2:0] TAG_2B  = 3'd2;
  localparam logic [2:0] TAG_4B  = 3'd3;
  localparam logic [2:0] TAG_8B  = 3'd4;
  localparam logic [2:0] TAG_16B = 3'd5;

  // Classified operation, operands left-aligned so the first byte sits on top
  typedef struct packed {
    logic [VAL_W-1:0]   a;
    logic [VAL_W-1:0]   b;
    logic [VAL_W-1:0]   c;
    logic [CNT_W-1:0]   nbytes;
    logic [STAMP_W-1:0] stamp;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/bto_front.sv]
// ---------------------------------------------------------------------------
// Front end
// Accepts commands, drops meaningless ones, computes the result and aligns
// the selected low bytes to the top of each value.
// ---------------------------------------------------------------------------
module bto_front (
  input  logic                        start,
  input  logic [1:0]                  in_cmd,
  input  logic [63:0]                 in_a_hi,
  input  logic [63:0]                 in_a_lo,
  input  logic [63:0]                 in_b_hi,
  input  logic [63:0]                 in_b_lo,
  input  logic [2:0]                  in_width_tag,
  input  logic [bto_pkg::STAMP_W-1:0] in_clock_stamp,
  input  bto_pkg::fifo_stat_t         stat,
  output logic                        push,
  output bto_pkg::item_t              item
);

  logic [bto_pkg::VAL_W-1:0] a_full;
  logic [bto_pkg::VAL_W-1:0] b_full;
  logic [bto_pkg::VAL_W-1:0] c_full;
  logic [bto_pkg::CNT_W-1:0] nbytes;
  logic [7:0]                shamt;
  logic                      tag_ok;
  logic                      cmd_ok;

  assign a_full = {in_a_hi, in_a_lo};
  assign b_full = {in_b_hi, in_b_lo};

  always_comb begin
    cmd_ok = 1'b1;
    unique case (in_cmd)
      bto_pkg::CMD_AND: c_full = a_full & b_full;
      bto_pkg::CMD_OR:  c_full = a_full | b_full;
      bto_pkg::CMD_XOR: c_full = a_full ^ b_full;
      default: begin
        c_full = '0;
        cmd_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    tag_ok = 1'b1;
    unique case (in_width_tag)
      bto_pkg::TAG_1B:  nbytes = bto_pkg::CNT_W'(1);
      bto_pkg::TAG_2B:  nbytes = bto_pkg::CNT_W'(2);
      bto_pkg::TAG_4B:  nbytes = bto_pkg::CNT_W'(4);
      bto_pkg::TAG_8B:  nbytes = bto_pkg::CNT_W'(8);
      bto_pkg::TAG_16B: nbytes = bto_pkg::CNT_W'(16);
      default: begin
        nbytes = '0;
        tag_ok = 1'b0;
      end
    endcase
    if (nbytes > bto_pkg::CNT_W'(bto_pkg::MAX_BYTES)) begin
      tag_ok = 1'b0;
    end
  end

  // Shift out the unused upper bytes; the first byte to emit lands on top
  assign shamt = 8'(bto_pkg::VAL_W) - {nbytes[4:0], 3'b000};

  assign push        = start && !stat.full && tag_ok && cmd_ok;
  assign item.a      = a_full << shamt;
  assign item.b      = b_full << shamt;
  assign item.c      = c_full << shamt;
  assign item.nbytes = nbytes;
  assign item.stamp  = in_clock_stamp;

endmodule

[rtl/bto_fifo.sv]
// ---------------------------------------------------------------------------
// Decoupling queue
// Two-entry queue between the front end and the row emitter.
// ---------------------------------------------------------------------------
module bto_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bto_pkg::item_t      wr_item,
  input  logic                pop,
  output bto_pkg::item_t      rd_item,
  output bto_pkg::fifo_stat_t stat
);

  bto_pkg::item_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= wr_item;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign rd_item    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

endmodule

[rtl/bto_back.sv]
// ---------------------------------------------------------------------------
// Row emitter
// Walks one queued operation a row per cycle, shifting out big-endian bytes
// and building the running accumulators.
// ---------------------------------------------------------------------------
module bto_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bto_pkg::fifo_stat_t         stat,
  input  bto_pkg::item_t              item,
  output logic                        pop,
  output logic                        out_valid,
  output logic [4:0]                  out_row_index,
  output logic                        out_last,
  output logic [7:0]                  out_byte_a,
  output logic [7:0]                  out_byte_b,
  output logic [7:0]                  out_byte_c,
  output logic [bto_pkg::VAL_W-1:0]   acc_a,
  output logic [bto_pkg::VAL_W-1:0]   acc_b,
  output logic [bto_pkg::VAL_W-1:0]   acc_c,
  output logic [bto_pkg::STAMP_W-1:0] out_row_clock
);

  localparam int VW = bto_pkg::VAL_W;

  logic                        active_r;
  logic [VW-1:0]               a_r;
  logic [VW-1:0]               b_r;
  logic [VW-1:0]               c_r;
  logic [VW-1:0]               acc_a_r;
  logic [VW-1:0]               acc_b_r;
  logic [VW-1:0]               acc_c_r;
  logic [bto_pkg::CNT_W-1:0]   row_r;
  logic [bto_pkg::CNT_W-1:0]   nbytes_r;
  logic [bto_pkg::STAMP_W-1:0] stamp_r;

  logic                        valid_r;
  logic [4:0]                  row_out_r;
  logic                        last_out_r;
  logic [7:0]                  byte_a_r;
  logic [7:0]                  byte_b_r;
  logic [7:0]                  byte_c_r;
  logic [VW-1:0]               acc_a_out_r;
  logic [VW-1:0]               acc_b_out_r;
  logic [VW-1:0]               acc_c_out_r;
  logic [bto_pkg::STAMP_W-1:0] clock_out_r;

  logic       last_row;
  logic [7:0] byte_a_nxt;
  logic [7:0] byte_b_nxt;
  logic [7:0] byte_c_nxt;

  assign last_row = active_r && (row_r == nbytes_r);
  // Load the next operation on the closing row so items run back to back
  assign pop      = !stat.empty && (!active_r || last_row);

  assign byte_a_nxt = last_row ? 8'd0 : a_r[VW-1 -: 8];
  assign byte_b_nxt = last_row ? 8'd0 : b_r[VW-1 -: 8];
  assign byte_c_nxt = last_row ? 8'd0 : c_r[VW-1 -: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= active_r;
      if (active_r) begin
        row_out_r   <= row_r;
        last_out_r  <= last_row;
        byte_a_r    <= byte_a_nxt;
        byte_b_r    <= byte_b_nxt;
        byte_c_r    <= byte_c_nxt;
        acc_a_out_r <= acc_a_r;
        acc_b_out_r <= acc_b_r;
        acc_c_out_r <= acc_c_r;
        clock_out_r <= stamp_r;
      end
      if (pop) begin
        active_r <= 1'b1;
        a_r      <= item.a;
        b_r      <= item.b;
        c_r      <= item.c;
        acc_a_r  <= '0;
        acc_b_r  <= '0;
        acc_c_r  <= '0;
        row_r    <= '0;
        nbytes_r <= item.nbytes;
        stamp_r  <= item.stamp;
      end else if (active_r) begin
        // advance to the next byte
        a_r     <= a_r << 8;
        b_r     <= b_r << 8;
        c_r     <= c_r << 8;
        acc_a_r <= {acc_a_r[VW-9:0], byte_a_nxt};
        acc_b_r <= {acc_b_r[VW-9:0], byte_b_nxt};
        acc_c_r <= {acc_c_r[VW-9:0], byte_c_nxt};
        row_r   <= row_r + bto_pkg::CNT_W'(1);
        if (last_row) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid     = valid_r;
  assign out_row_index = row_out_r;
  assign out_last      = last_out_r;
  assign out_byte_a    = byte_a_r;
  assign out_byte_b    = byte_b_r;
  assign out_byte_c    = byte_c_r;
  assign acc_a         = acc_a_out_r;
  assign acc_b         = acc_b_out_r;
  assign acc_c         = acc_c_out_r;
  assign out_row_clock = clock_out_r;

endmodule

[rtl/bitwise_op_byte_trace_emitter.sv]
// ---------------------------------------------------------------------------
// Bitwise operation byte trace emitter
// Top level: front end, two-entry queue and row emitter.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A valid command
// (AND, OR or XOR with width tag 1 to 5) of N bytes produces N+1 rows, one
// per cycle on a single-cycle out_valid strobe, the first row once the command
// has passed the queue, the row emitter and its output registers; other
// commands produce nothing. The row emitter handles one row a cycle, so a
// command occupies it for its N+1 rows, and queued commands follow without a
// gap. The result side cannot stall: rows must be taken as they appear. busy
// rises while the two-entry queue in front of the row emitter is full.
`include "bitwise_op_byte_trace_emitter_macros.svh"

module bitwise_op_byte_trace_emitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_a_hi,
  input  logic [63:0] in_a_lo,
  input  logic [63:0] in_b_hi,
  input  logic [63:0] in_b_lo,
  input  logic [2:0]  in_width_tag,
  input  logic [31:0] in_clock_stamp,
  output logic        out_valid,
  output logic [4:0]  out_row_index,
  output logic        out_last,
  output logic [7:0]  out_byte_a,
  output logic [7:0]  out_byte_b,
  output logic [7:0]  out_byte_c,
  output logic [63:0] out_acc_a_hi,
  output logic [63:0] out_acc_a_lo,
  output logic [63:0] out_acc_b_hi,
  output logic [63:0] out_acc_b_lo,
  output logic [63:0] out_acc_c_hi,
  output logic [63:0] out_acc_c_lo,
  output logic [31:0] out_row_clock
);

  bto_pkg::fifo_stat_t       stat;
  bto_pkg::item_t            wr_item;
  bto_pkg::item_t            rd_item;
  logic                      push;
  logic                      pop;
  logic [bto_pkg::VAL_W-1:0] acc_a;
  logic [bto_pkg::VAL_W-1:0] acc_b;
  logic [bto_pkg::VAL_W-1:0] acc_c;

  bto_front u_front (
    .start          (start),
    .in_cmd         (in_cmd),
    .in_a_hi        (in_a_hi),
    .in_a_lo        (in_a_lo),
    .in_b_hi        (in_b_hi),
    .in_b_lo        (in_b_lo),
    .in_width_tag   (in_width_tag),
    .in_clock_stamp (in_clock_stamp),
    .stat           (stat),
    .push           (push),
    .item           (wr_item)
  );

  bto_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .stat    (stat)
  );

  bto_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .stat          (stat),
    .item          (rd_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_row_index (out_row_index),
    .out_last      (out_last),
    .out_byte_a    (out_byte_a),
    .out_byte_b    (out_byte_b),
    .out_byte_c    (out_byte_c),
    .acc_a         (acc_a),
    .acc_b         (acc_b),
    .acc_c         (acc_c),
    .out_row_clock (out_row_clock)
  );

  assign busy         = stat.full;
  assign out_acc_a_hi = acc_a[127:64];
  assign out_acc_a_lo = acc_a[63:0];
  assign out_acc_b_hi = acc_b[127:64];
  assign out_acc_b_lo = acc_b[63:0];
  assign out_acc_c_hi = acc_c[127:64];
  assign out_acc_c_lo = acc_c[63:0];

  `BTO_ASSERT(a_last_bytes_zero, clk, rst_n, (out_valid && out_last) |-> (out_byte_a == 8'd0 && out_byte_b == 8'd0 && out_byte_c == 8'd0), "final row carries a non-zero byte")
  `BTO_ASSERT(a_rows_contiguous, clk, rst_n, (out_valid && !out_last) |=> (out_valid && out_row_index == $past(out_row_index) + 5'd1), "row sequence broken")
  `BTO_ASSERT(a_first_row_acc_clear, clk, rst_n, (out_valid && out_row_index == 5'd0) |-> (acc_a == '0 && acc_b == '0 && acc_c == '0), "accumulator not cleared on first row")
  `BTO_ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push && stat.full, "queue written while full")

endmodule
